>>> rtl/cta_pkg.sv
package cta_pkg;

	localparam int DEF_CHUNK_W     = 16;
	localparam int DEF_CHUNK_H     = 16;
	localparam int DEF_TABLE_DEPTH = 64;

	localparam int TILE_W  = 32;
	localparam int KEY_W   = 64;
	localparam int OSLOT_W = 6;
	localparam int TIDX_W  = 8;
	localparam int CHUNK_W_OUT = 28;
	localparam int REM_W   = 8;

	typedef logic [KEY_W-1:0] cta_key_t;

	// search token walking the cell chain
	typedef struct packed {
		logic valid;
		logic hit;
	} cta_tok_t;

endpackage

>>> rtl/cta_floordiv.sv
module cta_floordiv import cta_pkg::*; #(
	parameter int D = DEF_CHUNK_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic signed [TILE_W-1:0] value,
	output logic                     out_valid,
	output logic signed [TILE_W-1:0] quot,
	output logic [REM_W-1:0]         rem
);

	// floor(2^31 / D); the estimate is low by at most one
	localparam logic [31:0]      RECIP_C = 32'((64'h8000_0000) / 64'(D));
	localparam logic [8:0]       DIV_C   = 9'(D);
	localparam logic [REM_W-1:0] DM1_C   = REM_W'(D - 1);

	logic        v_s1, v_s2, v_s3;
	logic        neg_s1, neg_s2;
	logic [30:0] w_s1, w_s2;
	logic [62:0] prod_s1;
	logic [30:0] qe_s2, qd_s2;
	logic signed [TILE_W-1:0] quot_s3;
	logic [REM_W-1:0]         rem_s3;

	logic [30:0] w_in;
	logic [30:0] diff, r_fix, q_fix;
	logic        fix;

	// fold negatives: floor(v/D) = ~floor(~v/D)
	assign w_in = value[31] ? ~value[30:0] : value[30:0];

	assign diff  = w_s2 - qd_s2;
	assign fix   = diff >= 31'(DIV_C);
	assign q_fix = qe_s2 + 31'(fix);
	assign r_fix = fix ? diff - 31'(DIV_C) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			neg_s1  <= value[31];
			w_s1    <= w_in;
			prod_s1 <= 63'(w_in) * 63'(RECIP_C);
		end
		if (v_s1) begin
			neg_s2 <= neg_s1;
			w_s2   <= w_s1;
			qe_s2  <= prod_s1[61:31];
			qd_s2  <= 31'(40'(prod_s1[61:31]) * 40'(DIV_C));
		end
		if (v_s2) begin
			quot_s3 <= neg_s2 ? ~{1'b0, q_fix} : {1'b0, q_fix};
			rem_s3  <= neg_s2 ? DM1_C - r_fix[REM_W-1:0] : r_fix[REM_W-1:0];
		end
	end

	assign out_valid = v_s3;
	assign quot      = quot_s3;
	assign rem       = rem_s3;

endmodule

>>> rtl/cta_cell.sv
module cta_cell import cta_pkg::*; #(
	parameter int IDX    = 0,
	parameter int SLOT_W = 6,
	parameter int CNT_W  = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CNT_W-1:0]  count,
	input  cta_key_t          key_i,
	input  cta_tok_t          tok_i,
	input  logic [SLOT_W-1:0] slot_i,
	output cta_key_t          key_o,
	output cta_tok_t          tok_o,
	output logic [SLOT_W-1:0] slot_o,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_slot,
	input  cta_key_t          wr_key
);

	cta_key_t          entry_q;
	cta_key_t          key_q;
	cta_tok_t          tok_q;
	logic [SLOT_W-1:0] slot_q;
	logic              match;

	// only entries below the fill count take part
	assign match = tok_i.valid && !tok_i.hit && (CNT_W'(IDX) < count) && (entry_q == key_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_i.valid;
			tok_q.hit   <= tok_i.hit | match;
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= key_i;
		slot_q <= match ? SLOT_W'(IDX) : slot_i;
		if (wr_en && wr_slot == SLOT_W'(IDX)) begin
			entry_q <= wr_key;
		end
	end

	assign key_o  = key_q;
	assign tok_o  = tok_q;
	assign slot_o = slot_q;

endmodule

>>> rtl/chunk_tile_address_allocate.sv
// Chunk tile address allocator: floor-divide a world tile coordinate into chunk and
// offset, look the chunk up in a chain of table cells, append it on a miss.
// Path of a word: 3 divider stages, the table cells of the search chain, one output
// register with a pending stage behind it. The chain carries one search at a time: a new
// word is taken only once the last result has entered the output register.
// Reset clears the fill count and all handshake state; table keys are not cleared.
module chunk_tile_address_allocate import cta_pkg::*; #(
	parameter int CHUNK_W     = DEF_CHUNK_W,
	parameter int CHUNK_H     = DEF_CHUNK_H,
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [TILE_W-1:0]      tile_x,
	input  logic signed [TILE_W-1:0]      tile_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [OSLOT_W-1:0]            slot,
	output logic [TIDX_W-1:0]             tile_index,
	output logic signed [CHUNK_W_OUT-1:0] chunk_x,
	output logic signed [CHUNK_W_OUT-1:0] chunk_y,
	output logic                          created,
	output logic                          table_full
);

	localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam logic [8:0] W_C = 9'(CHUNK_W);

	// accept a word only when no earlier word is still in flight
	logic accept;
	logic busy_q;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;

	// floor division of each coordinate
	logic                     vx, vy, launch;
	logic signed [TILE_W-1:0] qx, qy;
	logic [REM_W-1:0]         rx, ry;

	cta_floordiv #(.D(CHUNK_W)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.value    (tile_x),
		.out_valid(vx),
		.quot     (qx),
		.rem      (rx)
	);

	cta_floordiv #(.D(CHUNK_H)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.value    (tile_y),
		.out_valid(vy),
		.quot     (qy),
		.rem      (ry)
	);

	assign launch = vx && vy;

	// hold the address fields of the word while its search walks the chain
	logic [15:0]                   tidx_full;
	logic [TIDX_W-1:0]             tidx_h_q;
	logic signed [CHUNK_W_OUT-1:0] cx_h_q, cy_h_q;

	assign tidx_full = 16'(ry) * 16'(W_C) + 16'(rx);

	always_ff @(posedge clk) begin
		if (launch) begin
			tidx_h_q <= tidx_full[TIDX_W-1:0];
			cx_h_q   <= qx[CHUNK_W_OUT-1:0];
			cy_h_q   <= qy[CHUNK_W_OUT-1:0];
		end
	end

	// search chain: the key and hit token advance one cell per cycle
	logic [CNT_W-1:0]  entry_count_q;
	cta_key_t          key_c  [0:TABLE_DEPTH];
	cta_tok_t          tok_c  [0:TABLE_DEPTH];
	logic [SLOT_W-1:0] slot_c [0:TABLE_DEPTH];
	logic              wr_en;
	logic [SLOT_W-1:0] wr_slot;

	assign key_c[0]       = {qx, qy};
	assign tok_c[0].valid = launch;
	assign tok_c[0].hit   = 1'b0;
	assign slot_c[0]      = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		cta_cell #(
			.IDX   (i),
			.SLOT_W(SLOT_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.count  (entry_count_q),
			.key_i  (key_c[i]),
			.tok_i  (tok_c[i]),
			.slot_i (slot_c[i]),
			.key_o  (key_c[i+1]),
			.tok_o  (tok_c[i+1]),
			.slot_o (slot_c[i+1]),
			.wr_en  (wr_en),
			.wr_slot(wr_slot),
			.wr_key (key_c[TABLE_DEPTH])
		);
	end

	// chain end: resolve hit, append into the next free slot, or flag full
	logic              end_valid, room;
	logic              res_created, res_full;
	logic [SLOT_W-1:0] res_slot;

	assign end_valid   = tok_c[TABLE_DEPTH].valid;
	assign room        = entry_count_q < CNT_W'(TABLE_DEPTH);
	assign res_created = !tok_c[TABLE_DEPTH].hit && room;
	assign res_full    = !tok_c[TABLE_DEPTH].hit && !room;
	assign wr_slot     = SLOT_W'(entry_count_q);
	assign wr_en       = end_valid && res_created;
	assign res_slot    = tok_c[TABLE_DEPTH].hit ? slot_c[TABLE_DEPTH] :
	                     (room ? wr_slot : '0);

	// output register with one pending stage behind it
	logic                  out_valid_q, pend_valid_q, out_free;
	logic [SLOT_W-1:0]     pend_slot_q;
	logic                  pend_created_q, pend_full_q;
	logic [OSLOT_W-1:0]    slot_q;
	logic [TIDX_W-1:0]     tidx_q;
	logic signed [CHUNK_W_OUT-1:0] cx_q, cy_q;
	logic                  created_q, full_q;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			pend_valid_q  <= 1'b0;
			entry_count_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end
			if (end_valid) begin
				if (res_created) begin
					entry_count_q <= entry_count_q + CNT_W'(1);
				end
				if (out_free) begin
					out_valid_q <= 1'b1;
					busy_q      <= 1'b0;
				end else begin
					pend_valid_q <= 1'b1;
				end
			end else if (pend_valid_q) begin
				if (out_free) begin
					out_valid_q  <= 1'b1;
					pend_valid_q <= 1'b0;
					busy_q       <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (end_valid && !out_free) begin
			pend_slot_q    <= res_slot;
			pend_created_q <= res_created;
			pend_full_q    <= res_full;
		end
		if ((end_valid || pend_valid_q) && out_free) begin
			slot_q    <= OSLOT_W'(end_valid ? res_slot : pend_slot_q);
			created_q <= end_valid ? res_created : pend_created_q;
			full_q    <= end_valid ? res_full : pend_full_q;
			tidx_q    <= tidx_h_q;
			cx_q      <= cx_h_q;
			cy_q      <= cy_h_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign slot       = slot_q;
	assign tile_index = tidx_q;
	assign chunk_x    = cx_q;
	assign chunk_y    = cy_q;
	assign created    = created_q;
	assign table_full = full_q;

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (out_valid_q && busy_q))
		else $error("pending word without a blocked output");

	assert property (@(posedge clk) disable iff (!arst_n)
		end_valid |-> busy_q)
		else $error("search finished with no word in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(created_q && full_q))
		else $error("created and full both set");

	assert property (@(posedge clk) disable iff (!arst_n)
		(end_valid && res_created) |=> (entry_count_q == $past(entry_count_q) + CNT_W'(1)))
		else $error("append did not advance the fill count");

endmodule

>>> dv/chunk_alloc_checker.sv
module chunk_alloc_checker import cta_pkg::*; #(
	parameter int CHUNK_W     = DEF_CHUNK_W,
	parameter int CHUNK_H     = DEF_CHUNK_H,
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [TILE_W-1:0]      tile_x,
	input  logic signed [TILE_W-1:0]      tile_y,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [OSLOT_W-1:0]            slot,
	input  logic [TIDX_W-1:0]             tile_index,
	input  logic signed [CHUNK_W_OUT-1:0] chunk_x,
	input  logic signed [CHUNK_W_OUT-1:0] chunk_y,
	input  logic                          created,
	input  logic                          table_full,
	output int                            errors,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [OSLOT_W-1:0]     slot;
		logic [TIDX_W-1:0]      tile_index;
		logic [CHUNK_W_OUT-1:0] chunk_x;
		logic [CHUNK_W_OUT-1:0] chunk_y;
		logic                   created;
		logic                   table_full;
	} alloc_word_t;

	// shadow of the chunk table: keys below chunk_count are live
	cta_key_t    chunk_table [TABLE_DEPTH];
	int          chunk_count;
	alloc_word_t expected_allocs [$];
	alloc_word_t want;
	int          words_seen;

	initial errors = 0;

	task automatic flag_mismatch(input string msg);
		$display("[%0t] word %0d: %s", $realtime, words_seen, msg);
		errors++;
	endtask

	// floor-divide both coordinates, look the chunk up, append on a miss
	function automatic alloc_word_t predict_allocation(input logic signed [TILE_W-1:0] tx,
			input logic signed [TILE_W-1:0] ty);
		longint      qx, rx, qy, ry, idx;
		cta_key_t    key;
		alloc_word_t w;
		bit          hit;
		w   = '0;
		hit = 1'b0;
		qx  = longint'(tx) / CHUNK_W;
		rx  = longint'(tx) % CHUNK_W;
		if (rx < 0) begin
			qx = qx - 1;
			rx = rx + CHUNK_W;
		end
		qy = longint'(ty) / CHUNK_H;
		ry = longint'(ty) % CHUNK_H;
		if (ry < 0) begin
			qy = qy - 1;
			ry = ry + CHUNK_H;
		end
		// the search uses the full 32-bit quotients
		key = {qx[31:0], qy[31:0]};
		for (int i = 0; i < chunk_count; i++) begin
			if (!hit && chunk_table[i] == key) begin
				hit    = 1'b1;
				w.slot = OSLOT_W'(i);
			end
		end
		if (!hit) begin
			if (chunk_count < TABLE_DEPTH) begin
				w.slot                   = OSLOT_W'(chunk_count);
				chunk_table[chunk_count] = key;
				chunk_count++;
				w.created                = 1'b1;
			end else begin
				w.table_full = 1'b1;
			end
		end
		idx          = ry * CHUNK_W + rx;
		w.tile_index = idx[TIDX_W-1:0];
		w.chunk_x    = qx[CHUNK_W_OUT-1:0];
		w.chunk_y    = qy[CHUNK_W_OUT-1:0];
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_allocs.delete();
			chunk_count = 0;
			words_seen  = 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_allocs.push_back(predict_allocation(tile_x, tile_y));
			if (out_valid && out_ready) begin
				if (expected_allocs.size() == 0) begin
					flag_mismatch("result word with no request outstanding");
				end else begin
					want = expected_allocs.pop_front();
					if (slot !== want.slot)
						flag_mismatch($sformatf("slot got %0d want %0d", slot, want.slot));
					if (tile_index !== want.tile_index)
						flag_mismatch($sformatf("tile_index got %0d want %0d",
							tile_index, want.tile_index));
					if (chunk_x !== want.chunk_x)
						flag_mismatch($sformatf("chunk_x got %h want %h", chunk_x, want.chunk_x));
					if (chunk_y !== want.chunk_y)
						flag_mismatch($sformatf("chunk_y got %h want %h", chunk_y, want.chunk_y));
					if (created !== want.created)
						flag_mismatch($sformatf("created got %b want %b", created, want.created));
					if (table_full !== want.table_full)
						flag_mismatch($sformatf("table_full got %b want %b",
							table_full, want.table_full));
				end
				words_seen++;
			end
			pending <= expected_allocs.size();
		end
	end

endmodule

>>> dv/tb_chunk_tile_address_allocate.sv
module tb_chunk_tile_address_allocate;
	timeunit 1ns;
	timeprecision 1ps;
	import cta_pkg::*;

	localparam int     CW          = DEF_CHUNK_W;
	localparam int     CH          = DEF_CHUNK_H;
	localparam int     DEPTH       = DEF_TABLE_DEPTH;
	localparam int     N_WORDS     = 1750;
	localparam int     LATENCY     = DEPTH + 4;
	// half-range of chunk coordinates that keep a tile inside 32 bits
	localparam longint TILE_SPAN   = 64'sd1 << 31;
	localparam longint CX_LIM      = TILE_SPAN / CW;
	localparam longint CY_LIM      = TILE_SPAN / CH;
	localparam int     DIR_N       = 20;
	localparam int     MIN_INT     = int'(32'h8000_0000);
	localparam int     MAX_INT     = int'(32'h7fff_ffff);

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [TILE_W-1:0]      tile_x;
	logic signed [TILE_W-1:0]      tile_y;
	logic                          out_valid;
	logic                          out_ready;
	logic [OSLOT_W-1:0]            slot;
	logic [TIDX_W-1:0]             tile_index;
	logic signed [CHUNK_W_OUT-1:0] chunk_x;
	logic signed [CHUNK_W_OUT-1:0] chunk_y;
	logic                          created;
	logic                          table_full;
	int                            errors;
	int                            pending;

	// chunk coordinates already requested; reusing them produces table hits
	int pool_cx [$];
	int pool_cy [$];
	int words_sent;
	int words_taken;

	// directed words: origin, repeats, negative rounding, the four corners of the
	// coordinate space, alternating bit patterns and opposite-sign offsets
	int dir_x [DIR_N] = '{0, 0, 15, -1, -16, -17, 16, MAX_INT, MIN_INT, MIN_INT,
		MAX_INT, int'(32'h5555_5555), int'(32'haaaa_aaaa), 1, -1, MAX_INT - 15,
		-15, 255, MIN_INT + 15, 0};
	int dir_y [DIR_N] = '{0, 0, 15, -1, -16, -17, -16, MAX_INT, MIN_INT, MAX_INT,
		MIN_INT, int'(32'haaaa_aaaa), int'(32'h5555_5555), -1, 1, MAX_INT - 15,
		-1, -256, MAX_INT, 0};

	chunk_tile_address_allocate #(
		.CHUNK_W     (CW),
		.CHUNK_H     (CH),
		.TABLE_DEPTH (DEPTH)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.tile_x     (tile_x),
		.tile_y     (tile_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot       (slot),
		.tile_index (tile_index),
		.chunk_x    (chunk_x),
		.chunk_y    (chunk_y),
		.created    (created),
		.table_full (table_full)
	);

	chunk_alloc_checker #(
		.CHUNK_W     (CW),
		.CHUNK_H     (CH),
		.TABLE_DEPTH (DEPTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.tile_x     (tile_x),
		.tile_y     (tile_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot       (slot),
		.tile_index (tile_index),
		.chunk_x    (chunk_x),
		.chunk_y    (chunk_y),
		.created    (created),
		.table_full (table_full),
		.errors     (errors),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// pick a tile at a random offset inside chunk c of the given size
	function automatic int tile_in_chunk(input int c, input int size);
		return c * size + int'($urandom_range(size - 1, 0));
	endfunction

	// present one word and hold it until the block takes it; called at a falling edge
	task automatic send_tile(input int x, input int y);
		int gap;
		// every fourth stretch of 128 words goes back to back
		gap = ((words_sent / 128) % 4 == 3) ? 0 : $urandom_range(4, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		tile_x   <= x;
		tile_y   <= y;
		// sample the handshake right at the rising edge, before the block updates
		do @(posedge clk); while (!in_ready);
		words_sent++;
		@(negedge clk);
	endtask

	// hold the sender off until every outstanding word has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// result side: drop out_ready for a random stall before each word, with stall-free stretches
	initial begin
		int stall;
		out_ready = 1'b0;
		words_taken = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = ((words_taken / 96) % 3 == 2) ? 0 : $urandom_range(4, 0);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			words_taken++;
			@(negedge clk);
		end
	end

	// stimulus and verdict
	initial begin
		int r, k, cx, cy;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		tile_x     = '0;
		tile_y     = '0;
		words_sent = 0;
		pool_cx    = '{0, -1, 1};
		pool_cy    = '{0, -1, -1};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed words first
		for (int i = 0; i < DIR_N; i++)
			send_tile(dir_x[i], dir_y[i]);
		drain_results();

		// random words: mostly reuse known chunks or nearby ones so the table
		// sees hits, appends and, once it fills, misses that cannot be stored
		for (int i = DIR_N; i < N_WORDS; i++) begin
			r = $urandom_range(99, 0);
			if (r < 55) begin
				k  = $urandom_range(pool_cx.size() - 1, 0);
				cx = pool_cx[k];
				cy = pool_cy[k];
			end else if (r < 80) begin
				cx = int'($urandom_range(11, 0)) - 6;
				cy = int'($urandom_range(11, 0)) - 6;
				pool_cx.push_back(cx);
				pool_cy.push_back(cy);
			end else begin
				// anywhere in the coordinate space: every tile bit toggles
				cx = int'(longint'($urandom_range(32'(2 * CX_LIM - 1), 0)) - CX_LIM);
				cy = int'(longint'($urandom_range(32'(2 * CY_LIM - 1), 0)) - CY_LIM);
				pool_cx.push_back(cx);
				pool_cy.push_back(cy);
			end
			send_tile(tile_in_chunk(cx, CW), tile_in_chunk(cy, CH));
			if (i % 500 == 0)
				drain_results();
		end
		in_valid <= 1'b0;

		// wait out the last words, then give stray output time to show up
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 16) @(negedge clk);

		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// drop the run if the block hangs
	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
rtl/cta_pkg.sv
rtl/cta_floordiv.sv
rtl/cta_cell.sv
rtl/chunk_tile_address_allocate.sv
dv/chunk_alloc_checker.sv
dv/tb_chunk_tile_address_allocate.sv
